// ===== hdl/scd_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse column dot package
// Shared constants, input codes and the controller-to-datapath command type.
// ----------------------------------------------------------------------------
package scd_pkg;

  // Field widths of the item and result ports.
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COL_W   = 16;
  localparam int unsigned SUM_W   = 64;

  // Vector store depth. It is a power of two, so an index that reaches past
  // the store wraps by dropping its upper bits.
  localparam int unsigned VECTOR_DEPTH = 4096;
  localparam int unsigned STORE_AW     = $clog2(VECTOR_DEPTH);

  // Column counter wraps to zero at MAX_COLUMNS.
  localparam int unsigned MAX_COLUMNS = 65536;
  localparam int unsigned CNT_W       = $clog2(MAX_COLUMNS);

  // Item function codes. The fourth code is ignored.
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ENTRY   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_wr;   // write the item value into the vector store
    logic store_rd;   // read the vector entry and capture the item value
    logic load_prod;  // register the product of value and vector entry
    logic accumulate; // saturating add of the product into the accumulator
    logic emit;       // present the column result and start a new column
    logic restart;    // clear accumulator, counter and saturation flag
  } scd_cmd_t;

endpackage

// ===== hdl/scd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, with registered read data.
// ----------------------------------------------------------------------------
module scd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write or read the addressed word.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/scd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sparse column dot controller
// Takes items while idle and steps the datapath through read, multiply,
// accumulate and emit.
// ----------------------------------------------------------------------------
module scd_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [scd_pkg::FUNC_W-1:0]  func_i,
  input  logic                        has_entry_i,
  input  logic                        ends_column_i,
  output scd_pkg::scd_cmd_t           cmd_o
);

  import scd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_ACC  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       ends_q, ends_d;
  logic       accept;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    ends_d  = ends_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (func_i)
            FUNC_LOAD: begin
              cmd_o.store_wr = 1'b1;
            end
            FUNC_ENTRY: begin
              ends_d = ends_column_i;
              if (has_entry_i) begin
                cmd_o.store_rd = 1'b1;
                state_d        = S_MUL;
              end else if (ends_column_i) begin
                state_d = S_EMIT;
              end
            end
            FUNC_RESTART: begin
              cmd_o.restart = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_MUL: begin
        cmd_o.load_prod = 1'b1;
        state_d         = S_ACC;
      end
      S_ACC: begin
        cmd_o.accumulate = 1'b1;
        state_d          = ends_q ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ends_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ends_q  <= ends_d;
    end
  end

endmodule

// ===== hdl/scd_dp.sv =====
// ----------------------------------------------------------------------------
// Sparse column dot datapath
// Vector store, multiplier, saturating accumulator, column counter and the
// result register.
// ----------------------------------------------------------------------------
module scd_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  scd_pkg::scd_cmd_t           cmd_i,
  input  logic [scd_pkg::INDEX_W-1:0] index_i,
  input  logic [scd_pkg::VALUE_W-1:0] value_i,
  output logic                        strobe_o,
  output logic [scd_pkg::COL_W-1:0]   column_o,
  output logic [scd_pkg::SUM_W-1:0]   sum_o,
  output logic                        saturated_o
);

  import scd_pkg::*;

  logic [VALUE_W-1:0]        rdata;
  logic [VALUE_W-1:0]        val_q;
  logic signed [SUM_W-1:0]   prod_full;
  logic [SUM_W-1:0]          prod_q;
  logic [SUM_W-1:0]          acc_q, acc_d;
  logic                      sat_q, sat_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      strobe_q;
  logic [COL_W-1:0]          column_q;
  logic [SUM_W-1:0]          sum_q;
  logic                      saturated_q;
  logic [SUM_W-1:0]          raw_sum;
  logic                      ovf;

  // Vector store; out-of-range indexes wrap on the low address bits.
  scd_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (cmd_i.store_wr || cmd_i.store_rd),
    .we_i    (cmd_i.store_wr),
    .addr_i  (STORE_AW'(index_i)),
    .wdata_i (value_i),
    .rdata_o (rdata)
  );

  // Signed 32x32 multiply, evaluated at the full 64-bit product width.
  assign prod_full = $signed(val_q) * $signed(rdata);

  // Item value and exact Q32.32 product.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_rd) begin
      val_q <= value_i;
    end
    if (cmd_i.load_prod) begin
      prod_q <= prod_full;
    end
  end

  // Saturating add: overflow when both operands share a sign the sum lacks.
  assign raw_sum = acc_q + prod_q;
  assign ovf     = (acc_q[SUM_W-1] == prod_q[SUM_W-1]) &&
                   (raw_sum[SUM_W-1] != acc_q[SUM_W-1]);

  // Accumulator, saturation flag and column counter updates.
  always_comb begin
    acc_d = acc_q;
    sat_d = sat_q;
    cnt_d = cnt_q;
    priority if (cmd_i.restart) begin
      acc_d = '0;
      sat_d = 1'b0;
      cnt_d = '0;
    end else if (cmd_i.accumulate) begin
      if (ovf) begin
        acc_d = prod_q[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        sat_d = 1'b1;
      end else begin
        acc_d = raw_sum;
      end
    end else if (cmd_i.emit) begin
      acc_d = '0;
      sat_d = 1'b0;
      cnt_d = (cnt_q == CNT_W'(MAX_COLUMNS - 1)) ? '0 : cnt_q + 1'b1;
    end else begin
      // Nothing to update; the column state holds.
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      sat_q    <= 1'b0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      sat_q    <= sat_d;
      cnt_q    <= cnt_d;
      strobe_q <= cmd_i.emit;
    end
  end

  // Result register, loaded on an emit; strobe_o marks it in the cycle after the emit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      column_q    <= COL_W'(cnt_q);
      sum_q       <= acc_q;
      saturated_q <= sat_q;
    end
  end

  assign strobe_o    = strobe_q;
  assign column_o    = column_q;
  assign sum_o       = sum_q;
  assign saturated_o = saturated_q;

endmodule

// ===== hdl/sparse_csc_column_dot.sv =====
// ----------------------------------------------------------------------------
// Sparse CSC column dot product
// Loads a dense vector, then dots each streamed sparse column with it.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Vector loads, restarts,
// ignored codes and column entries without a nonzero or mark leave busy low.
// A column mark with no nonzero passes through the emit state. A nonzero steps
// through a registered vector store read, a registered 32x32 multiply and a
// 64-bit saturating add, then through the emit state if it also closes the
// column. A column's result is loaded into the result ports and strobe_o is
// high for exactly one cycle, in the first cycle with busy low; the receiver
// cannot stall it, so it must take every transfer in that cycle.
module sparse_csc_column_dot (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [scd_pkg::FUNC_W-1:0]  func_i,
  input  logic [scd_pkg::INDEX_W-1:0] index_i,
  input  logic [scd_pkg::VALUE_W-1:0] value_i,
  input  logic                        has_entry_i,
  input  logic                        ends_column_i,
  output logic                        strobe_o,
  output logic [scd_pkg::COL_W-1:0]   column_o,
  output logic [scd_pkg::SUM_W-1:0]   sum_o,
  output logic                        saturated_o
);

  import scd_pkg::*;

  scd_cmd_t cmd;

  // Sequencer.
  scd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .has_entry_i   (has_entry_i),
    .ends_column_i (ends_column_i),
    .cmd_o         (cmd)
  );

  // Store, arithmetic and result register.
  scd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .index_i     (index_i),
    .value_i     (value_i),
    .strobe_o    (strobe_o),
    .column_o    (column_o),
    .sum_o       (sum_o),
    .saturated_o (saturated_o)
  );

  // A result follows a busy cycle and never repeats in the next cycle.
  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("result strobe held for more than one cycle");

  // A nonzero keeps the block busy; a vector load does not.
  a_entry_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FUNC_ENTRY && has_entry_i) |=> busy)
    else $error("nonzero transfer did not start the multiply sequence");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FUNC_LOAD) |=> (!busy && !strobe_o))
    else $error("vector load left the block busy or produced a result");

endmodule
